// ===== design/animation_frame_compositor_assert.svh =====
// ------------------------------------------------------------------------
// animation_frame_compositor_assert.svh
// Assertion macros for the frame compositor; empty when SYNTH is defined.
// ------------------------------------------------------------------------
`ifndef ANIMATION_FRAME_COMPOSITOR_ASSERT_SVH
`define ANIMATION_FRAME_COMPOSITOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define AFC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("compositor check failed: same-cycle implication");
// next-cycle implication, disabled in reset
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("compositor check failed: next-cycle implication");
`else
`define AFC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/afc_pkg.sv =====
// ------------------------------------------------------------------------
// afc_pkg
// Shared types and constants of the animation frame compositor.
// ------------------------------------------------------------------------
package afc_pkg;

    localparam int MAX_CANVAS_WIDTH_DEF  = 256;
    localparam int MAX_CANVAS_HEIGHT_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;
    localparam int PIX_W       = 32;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DISPOSE,
        ST_BLEND_MUL,
        ST_BLEND_WR,
        ST_READ_OUT
    } t_state;

    // input word without its kind
    typedef struct packed {
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [8:0] frame_width;
        logic [8:0] frame_height;
        logic       no_blend;
        logic       dispose_background;
        logic [7:0] src_blue;
        logic [7:0] src_green;
        logic [7:0] src_red;
        logic [7:0] src_alpha;
    } t_item;

    typedef struct packed {
        logic sweep_wr;      // zero one canvas entry of the clearing pass
        logic disp_wr;       // zero one pixel of the disposed rectangle
        logic frame_load;    // record new frame, arm disposal walk
        logic clear_state;   // forget frame history
        logic pix_wr_direct; // overwrite pixel from the input word
        logic pix_rd;        // read destination pixel for blending
        logic pix_mul;       // register blend products
        logic pix_wr_blend;  // write blended pixel
        logic cnt_step;      // advance raster counter
        logic rd_issue;      // canvas read for a read word
        logic out_load;      // load result register
    } t_cmd;

    typedef struct packed {
        logic pix_active;
        logic pix_on;
        logic blend_off;
        logic disp_needed;
        logic disp_last;
        logic sweep_last;
    } t_stat;

endpackage

// ===== design/afc_ram.sv =====
// ------------------------------------------------------------------------
// afc_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
module afc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/afc_ctrl.sv =====
// ------------------------------------------------------------------------
// afc_ctrl
// Sequencer of the compositor: item decode, sweeps, blend steps, result.
// ------------------------------------------------------------------------
module afc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic [1:0]     i_kind,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  afc_pkg::t_stat i_stat,
    output afc_pkg::t_cmd  o_cmd
);
    import afc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        accept  = i_s_tvalid && (r_state == ST_IDLE);
        case (r_state)
            ST_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_FRAME: begin
                            cmd.frame_load = 1'b1;
                            if (i_stat.disp_needed) begin
                                n_state = ST_DISPOSE;
                            end
                        end
                        KIND_PIXEL: begin
                            if (i_stat.pix_active) begin
                                if (i_stat.pix_on && !i_stat.blend_off) begin
                                    cmd.pix_rd = 1'b1;
                                    n_state    = ST_BLEND_MUL;
                                end else begin
                                    cmd.cnt_step      = 1'b1;
                                    cmd.pix_wr_direct = i_stat.pix_on;
                                end
                            end
                        end
                        KIND_READ: begin
                            cmd.rd_issue = 1'b1;
                            n_state      = ST_READ_OUT;
                        end
                        KIND_CLEAR: begin
                            cmd.clear_state = 1'b1;
                            n_state         = ST_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DISPOSE: begin
                cmd.disp_wr = 1'b1;
                if (i_stat.disp_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BLEND_MUL: begin
                cmd.pix_mul = 1'b1;
                n_state     = ST_BLEND_WR;
            end
            ST_BLEND_WR: begin
                cmd.pix_wr_blend = 1'b1;
                cmd.cnt_step     = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_READ_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

endmodule

// ===== design/afc_datapath.sv =====
// ------------------------------------------------------------------------
// afc_datapath
// Canvas RAM, frame registers, raster and sweep counters, blend arithmetic.
// ------------------------------------------------------------------------
module afc_datapath #(
    parameter int MAX_CANVAS_WIDTH  = afc_pkg::MAX_CANVAS_WIDTH_DEF,
    parameter int MAX_CANVAS_HEIGHT = afc_pkg::MAX_CANVAS_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  afc_pkg::t_item                    i_item,
    input  afc_pkg::t_cmd                     i_cmd,
    output afc_pkg::t_stat                    o_stat,
    output logic [afc_pkg::OUT_TDATA_W-1:0]   o_out_data
);
    import afc_pkg::*;

    localparam int XW    = $clog2(MAX_CANVAS_WIDTH);
    localparam int YW    = $clog2(MAX_CANVAS_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    // exact v/255 for any v up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'd1 + 17'(v[15:8]);
        return t[15:8];
    endfunction

    // configuration and frame state
    logic [8:0]    r_cfg_w, r_cfg_h;
    logic [7:0]    r_left, r_top;
    logic [8:0]    r_wide, r_tall;
    logic          r_dispose, r_have_prev, r_blend_off;
    logic [8:0]    r_col, r_row;
    logic [AW-1:0] r_sweep;
    // disposal walk
    logic [9:0]    r_dx, r_dy, r_dx_start, r_dx_lim, r_dy_lim;
    // blend pipeline and read
    logic [31:0]   r_src;
    logic [15:0]   r_mb, r_mg, r_mr, r_ma;
    logic          r_rd_on;
    logic [31:0]   r_out_data;

    logic [8:0]    eff_w, eff_h;
    logic [9:0]    px, py, frame_xe, frame_ye;
    logic [AW-1:0] pix_addr, disp_addr, read_addr;
    logic          ram_we, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [31:0]   ram_wr_data, ram_rd_data, blend_data, item_pix;
    logic [7:0]    inv;
    logic [8:0]    alpha_sum;
    logic          col_wrap, disp_x_end;

    assign eff_w = (32'(r_cfg_w) > MAX_CANVAS_WIDTH)  ? 9'(MAX_CANVAS_WIDTH)  : r_cfg_w;
    assign eff_h = (32'(r_cfg_h) > MAX_CANVAS_HEIGHT) ? 9'(MAX_CANVAS_HEIGHT) : r_cfg_h;

    assign px = {2'b00, r_left} + {1'b0, r_col};
    assign py = {2'b00, r_top}  + {1'b0, r_row};

    assign pix_addr  = {YW'(py), XW'(px)};
    assign disp_addr = {YW'(r_dy), XW'(r_dx)};
    assign read_addr = {YW'(i_item.y_pos), XW'(i_item.x_pos)};

    assign item_pix = {i_item.src_alpha, i_item.src_red, i_item.src_green, i_item.src_blue};

    // unclipped end of the rectangle being recorded now as the previous one
    assign frame_xe = {2'b00, r_left} + {1'b0, r_wide};
    assign frame_ye = {2'b00, r_top}  + {1'b0, r_tall};

    assign col_wrap   = ({1'b0, r_col} + 10'd1) >= {1'b0, r_wide};
    assign disp_x_end = (r_dx + 10'd1) == r_dx_lim;

    assign o_stat.pix_active  = (r_wide != 9'd0) && (r_row < r_tall);
    assign o_stat.pix_on      = (px < {1'b0, eff_w}) && (py < {1'b0, eff_h});
    assign o_stat.blend_off   = r_blend_off;
    assign o_stat.disp_needed = r_have_prev && r_dispose && (r_wide != 9'd0)
                                && (r_tall != 9'd0) && ({1'b0, r_left} < eff_w)
                                && ({1'b0, r_top} < eff_h);
    assign o_stat.disp_last   = disp_x_end && ((r_dy + 10'd1) == r_dy_lim);
    assign o_stat.sweep_last  = &r_sweep;

    // blend write stage
    assign alpha_sum  = {1'b0, r_src[31:24]} + {1'b0, div255(r_ma)};
    assign blend_data = {(alpha_sum[8] ? 8'hFF : alpha_sum[7:0]),
                         div255(r_mr), div255(r_mg), div255(r_mb)};
    assign inv        = 8'hFF - r_src[31:24];

    always_comb begin
        ram_we      = i_cmd.sweep_wr || i_cmd.disp_wr || i_cmd.pix_wr_direct
                      || i_cmd.pix_wr_blend;
        ram_wr_addr = pix_addr;
        ram_wr_data = '0;
        if (i_cmd.sweep_wr) begin
            ram_wr_addr = r_sweep;
        end else if (i_cmd.disp_wr) begin
            ram_wr_addr = disp_addr;
        end
        if (i_cmd.pix_wr_direct) begin
            ram_wr_data = item_pix;
        end else if (i_cmd.pix_wr_blend) begin
            ram_wr_data = blend_data;
        end
        ram_rd_en   = i_cmd.pix_rd || i_cmd.rd_issue;
        ram_rd_addr = i_cmd.rd_issue ? read_addr : pix_addr;
    end

    afc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= 9'd256;
            r_cfg_h     <= 9'd256;
            r_left      <= '0;
            r_top       <= '0;
            r_wide      <= '0;
            r_tall      <= '0;
            r_dispose   <= 1'b0;
            r_have_prev <= 1'b0;
            r_blend_off <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_sweep     <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_CANVAS_WIDTH)) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_CANVAS_HEIGHT)) begin
                r_cfg_h <= i_cfg_data;
            end
            if (i_cmd.sweep_wr) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if (i_cmd.clear_state) begin
                r_left      <= '0;
                r_top       <= '0;
                r_wide      <= '0;
                r_tall      <= '0;
                r_dispose   <= 1'b0;
                r_have_prev <= 1'b0;
                r_blend_off <= 1'b0;
                r_col       <= '0;
                r_row       <= '0;
            end else if (i_cmd.frame_load) begin
                r_left      <= i_item.x_pos;
                r_top       <= i_item.y_pos;
                r_wide      <= i_item.frame_width;
                r_tall      <= i_item.frame_height;
                r_dispose   <= i_item.dispose_background;
                r_blend_off <= i_item.no_blend;
                r_have_prev <= 1'b1;
                r_col       <= '0;
                r_row       <= '0;
            end else if (i_cmd.cnt_step) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= r_row + 9'd1;
                end else begin
                    r_col <= r_col + 9'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_load) begin
            r_dx       <= {2'b00, r_left};
            r_dy       <= {2'b00, r_top};
            r_dx_start <= {2'b00, r_left};
            r_dx_lim   <= (frame_xe < {1'b0, eff_w}) ? frame_xe : {1'b0, eff_w};
            r_dy_lim   <= (frame_ye < {1'b0, eff_h}) ? frame_ye : {1'b0, eff_h};
        end else if (i_cmd.disp_wr) begin
            if (disp_x_end) begin
                r_dx <= r_dx_start;
                r_dy <= r_dy + 10'd1;
            end else begin
                r_dx <= r_dx + 10'd1;
            end
        end
        if (i_cmd.pix_rd) begin
            r_src <= item_pix;
        end
        if (i_cmd.pix_mul) begin
            r_mb <= 16'(r_src[7:0])   * 16'(r_src[31:24]) + 16'(ram_rd_data[7:0])   * 16'(inv);
            r_mg <= 16'(r_src[15:8])  * 16'(r_src[31:24]) + 16'(ram_rd_data[15:8])  * 16'(inv);
            r_mr <= 16'(r_src[23:16]) * 16'(r_src[31:24]) + 16'(ram_rd_data[23:16]) * 16'(inv);
            r_ma <= 16'(ram_rd_data[31:24]) * 16'(inv);
        end
        if (i_cmd.rd_issue) begin
            r_rd_on <= ({1'b0, i_item.x_pos} < eff_w) && ({1'b0, i_item.y_pos} < eff_h);
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_rd_on ? ram_rd_data : '0;
        end
    end

    assign o_out_data = r_out_data;

endmodule

// ===== design/animation_frame_compositor.sv =====
// ------------------------------------------------------------------------
// animation_frame_compositor - BGRA canvas compositing of animation frames.
// Input words: direct or dropped pixel handled in the idle state; blended pixel by RAM read,
// multiply, write on the one RAM; read: RAM read, result load; frame start: disposal walk.
// Reset and clear words run a clearing pass of 2**(clog2(W)+clog2(H)) entries, input halted.
// ------------------------------------------------------------------------
module animation_frame_compositor #(
    parameter int MAX_CANVAS_WIDTH  = afc_pkg::MAX_CANVAS_WIDTH_DEF,
    parameter int MAX_CANVAS_HEIGHT = afc_pkg::MAX_CANVAS_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] x_pos, [15:8] y_pos, [24:16] frame_width, [33:25] frame_height,
    // [34] no_blend, [35] dispose_background, [43:36] src_blue,
    // [51:44] src_green, [59:52] src_red, [67:60] src_alpha, [71:68] zero
    input  logic [afc_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [1:0] kind
    input  logic [1:0]                        i_s_tuser,
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] out_blue, [15:8] out_green, [23:16] out_red, [31:24] out_alpha
    output logic [afc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import afc_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_stat stat;

    // unpack the input word; kind travels on tuser to the sequencer
    assign item.x_pos              = i_s_tdata[7:0];
    assign item.y_pos              = i_s_tdata[15:8];
    assign item.frame_width        = i_s_tdata[24:16];
    assign item.frame_height       = i_s_tdata[33:25];
    assign item.no_blend           = i_s_tdata[34];
    assign item.dispose_background = i_s_tdata[35];
    assign item.src_blue           = i_s_tdata[43:36];
    assign item.src_green          = i_s_tdata[51:44];
    assign item.src_red            = i_s_tdata[59:52];
    assign item.src_alpha          = i_s_tdata[67:60];

    // the user must write registers only with the block idle (unenforced); always take them
    assign o_cfg_ready = 1'b1;

    // sequencer: clearing pass, disposal walk, blend steps, result handoff
    afc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // canvas RAM, frame rectangle, counters and blend arithmetic
    afc_datapath #(
        .MAX_CANVAS_WIDTH  (MAX_CANVAS_WIDTH),
        .MAX_CANVAS_HEIGHT (MAX_CANVAS_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_m_tdata)
    );

    // ---- checks ----
`include "animation_frame_compositor_assert.svh"

    // the canvas RAM has one write port: never two writers in a cycle
    `AFC_ASSERT_IMPLIES(a_one_writer, i_clk, i_rst_n, 1'b1, $onehot0({cmd.sweep_wr, cmd.disp_wr, cmd.pix_wr_direct, cmd.pix_wr_blend}))
    // a blended write always follows its destination read, with the multiply step between them
    `AFC_ASSERT_IMPLIES(a_blend_order, i_clk, i_rst_n, cmd.pix_wr_blend, $past(cmd.pix_rd, 2))
    // no word is taken while the clearing pass runs
    `AFC_ASSERT_IMPLIES(a_sweep_busy, i_clk, i_rst_n, cmd.sweep_wr, !o_s_tready)
    // a read word holds off input until its result is loaded into the output register
    `AFC_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, cmd.rd_issue, !o_s_tready)

endmodule
